@@ sv/bmii_pkg.sv @@
// bmii_pkg: shared constants, types and helpers of the box mean integral image unit.
// No dependencies; every other file of the block but bmii_ram imports it.
`default_nettype none
package bmii_pkg;

   localparam int MAX_LINES   = 1024;
   localparam int MAX_WING    = 15;
   localparam int RING_SLOTS  = 2 * MAX_WING + 2;
   localparam int RING_DEPTH  = RING_SLOTS * MAX_LINES;
   localparam int LINE_BITS   = $clog2(MAX_LINES);
   localparam int SLOT_BITS   = $clog2(RING_SLOTS);
   localparam int ADDR_BITS   = $clog2(RING_DEPTH);
   localparam int WING_BITS   = $clog2(MAX_WING + 1);
   localparam int N_BITS      = $clog2((2 * MAX_WING + 1) * (2 * MAX_WING + 1) + 1);
   localparam int QUOT_BITS   = 24;
   localparam int QCNT_BITS   = $clog2(QUOT_BITS);
   localparam int REM_BITS    = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);
   localparam int LW          = 14;

   typedef enum logic [2:0] {
      REG_IMAGE_SAMPLES,
      REG_IMAGE_LINES,
      REG_SAMPLE_OFFSET,
      REG_LINE_OFFSET,
      REG_OUT_SAMPLES,
      REG_OUT_LINES,
      REG_WING_SIZE,
      REG_NONE
   } csr_reg_type;

   typedef struct packed {
      logic [15:0] image_samples;
      logic [10:0] image_lines;
      logic [15:0] sample_offset;
      logic [9:0]  line_offset;
      logic [15:0] out_samples;
      logic [10:0] out_lines;
      logic [3:0]  wing_size;
   } cfg_type;

   typedef struct packed {
      logic [31:0]          run_sum;
      logic [SLOT_BITS-1:0] slot_cur;
      logic [SLOT_BITS-1:0] slot_prev;
      logic [SLOT_BITS-1:0] slot_c1;
      logic [LINE_BITS-1:0] line_cur;
      logic [LINE_BITS-1:0] line_l1;
      logic                 has_prev;
      logic                 c1_ok;
      logic                 l1_ok;
      logic                 emit;
      logic                 no_data;
      logic                 last;
      logic [15:0]          out_sample;
      logic [9:0]           out_line;
      logic [N_BITS-1:0]    area;
   } item_type;

   typedef struct packed {
      logic [23:0] mean_q8;
      logic [15:0] out_sample;
      logic [9:0]  out_line;
      logic        no_data;
      logic        last;
   } out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREV,
      ST_CORNER_A,
      ST_CORNER_B,
      ST_CORNER_C,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } back_state_type;

   function automatic logic [ADDR_BITS-1:0] ring_addr(input logic [SLOT_BITS-1:0] slot,
                                                      input logic [LINE_BITS-1:0] line);
      return ADDR_BITS'(slot * MAX_LINES + line);
   endfunction

endpackage
`default_nettype wire

@@ sv/bmii_ram.sv @@
// bmii_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module bmii_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ sv/bmii_front.sv @@
// bmii_front: input side; tracks the pixel position and running column sum and
// classifies each word into a work item for the back end. Depends on bmii_pkg.
`default_nettype none
module bmii_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bmii_pkg::cfg_type cfg,
   input  wire logic              in_valid,
   input  wire logic [15:0]       in_pixel,
   input  wire logic              queue_full,
   output logic                   in_ready,
   output logic                   push,
   output bmii_pkg::item_type     push_item
);
   import bmii_pkg::*;

   logic [15:0]          col_ff, col_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [31:0]          sum_ff, sum_in;

   logic [15:0]          samples_eff;
   logic [LW-1:0]        lines_eff;
   logic [WING_BITS-1:0] w;
   logic                 line_wrap;
   logic [15:0]          col_a, cc;
   logic [SLOT_BITS-1:0] slot_a, slot_c;
   logic [31:0]          sum_a, run;
   logic [LINE_BITS-1:0] ll;
   logic [17:0]          c_u;
   logic [LW-1:0]        l_u;
   logic [WING_BITS:0]   odd;
   logic [SLOT_BITS:0]   slot_diff;
   logic                 c_in, l_in, end_line;

   always_comb begin
      samples_eff = (cfg.image_samples == 16'd0) ? 16'd1 : cfg.image_samples;
      if (cfg.image_lines == 11'd0) begin
         lines_eff = LW'(1);
      end else if (LW'(cfg.image_lines) > LW'(MAX_LINES)) begin
         lines_eff = LW'(MAX_LINES);
      end else begin
         lines_eff = LW'(cfg.image_lines);
      end
      w = (int'(cfg.wing_size) > MAX_WING) ? WING_BITS'(MAX_WING) : WING_BITS'(cfg.wing_size);
      odd = {w, 1'b1};

      // move to the next column first if the line counter is past its limit
      line_wrap = LW'(line_ff) >= lines_eff;
      col_a  = line_wrap ? col_ff + 16'd1 : col_ff;
      slot_a = slot_ff;
      if (line_wrap) begin
         slot_a = (int'(slot_ff) == RING_SLOTS - 1) ? '0 : slot_ff + SLOT_BITS'(1);
      end
      sum_a = line_wrap ? 32'd0 : sum_ff;
      ll    = line_wrap ? '0 : line_ff;
      if (col_a >= samples_eff) begin
         cc     = 16'd0;
         slot_c = '0;
      end else begin
         cc     = col_a;
         slot_c = slot_a;
      end
      run = sum_a + {{16{in_pixel[15]}}, in_pixel};

      end_line = (LW'(ll) + LW'(1)) >= lines_eff;
      col_in   = cc;
      slot_in  = slot_c;
      line_in  = ll + LINE_BITS'(1);
      sum_in   = run;
      if (end_line) begin
         line_in = '0;
         sum_in  = 32'd0;
         if ({1'b0, cc} + 17'd1 >= {1'b0, samples_eff}) begin
            col_in  = 16'd0;
            slot_in = '0;
         end else begin
            col_in  = cc + 16'd1;
            slot_in = (int'(slot_c) == RING_SLOTS - 1) ? '0 : slot_c + SLOT_BITS'(1);
         end
      end

      c_u  = {2'b0, cc} - 18'(w) - {2'b0, cfg.sample_offset};
      l_u  = LW'(ll) - LW'(w) - LW'(cfg.line_offset);
      c_in = !c_u[17] && (c_u[15:0] < cfg.out_samples) && !c_u[16];
      l_in = !l_u[LW-1] && (l_u < LW'(cfg.out_lines));

      slot_diff = {1'b0, slot_c} + (SLOT_BITS+1)'(RING_SLOTS) - (SLOT_BITS+1)'(odd);
      if (slot_diff >= (SLOT_BITS+1)'(RING_SLOTS)) begin
         slot_diff = slot_diff - (SLOT_BITS+1)'(RING_SLOTS);
      end

      push_item.run_sum    = run;
      push_item.slot_cur   = slot_c;
      push_item.slot_prev  = (slot_c == '0) ? SLOT_BITS'(RING_SLOTS - 1) : slot_c - SLOT_BITS'(1);
      push_item.slot_c1    = slot_diff[SLOT_BITS-1:0];
      push_item.line_cur   = ll;
      push_item.line_l1    = ll - LINE_BITS'(odd);
      push_item.has_prev   = cc != 16'd0;
      push_item.c1_ok      = 17'(cc) >= 17'(odd);
      push_item.l1_ok      = LW'(ll) >= LW'(odd);
      push_item.emit       = c_in && l_in;
      push_item.no_data    = (17'(cc) < 17'({w, 1'b0})) || (LW'(ll) < LW'({w, 1'b0}));
      push_item.last       = ({1'b0, c_u[15:0]} + 17'd1 == {1'b0, cfg.out_samples})
                             && (l_u + LW'(1) == LW'(cfg.out_lines));
      push_item.out_sample = c_u[15:0];
      push_item.out_line   = l_u[9:0];
      push_item.area       = N_BITS'(odd * odd);
   end

   assign in_ready = !queue_full;
   assign push     = in_valid && !queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (push) begin
         col_ff  <= col_in;
         line_ff <= line_in;
         slot_ff <= slot_in;
         sum_ff  <= sum_in;
      end
   end
endmodule
`default_nettype wire

@@ sv/bmii_queue.sv @@
// bmii_queue: short register FIFO of work items between front and back end.
// Depends on bmii_pkg.
`default_nettype none
module bmii_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bmii_pkg::item_type push_item,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output bmii_pkg::item_type      head
);
   import bmii_pkg::*;

   item_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_WIDTH-1:0] cnt_ff, cnt_in;

   assign full  = int'(cnt_ff) == QUEUE_DEPTH;
   assign empty = cnt_ff == '0;
   assign head  = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (int'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_in = (int'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

@@ sv/bmii_back.sv @@
// bmii_back: back end; reads the integral ring, writes the new table entry, forms
// the window sum and divides it by the window area. Depends on bmii_pkg, bmii_ram.
`default_nettype none
module bmii_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               queue_empty,
   input  wire bmii_pkg::item_type head,
   output logic                    pop,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bmii_pkg::out_type       out_word
);
   import bmii_pkg::*;

   back_state_type        state_ff, state_in;
   item_type              item_ff, item_in;
   logic [31:0]           s_ff, s_in, acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [QUOT_BITS-1:0]  quo_ff, quo_in;
   logic [QCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   out_type               out_ff, out_in;

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
   logic [31:0]           rd_data, acc_fin, mag;
   logic [REM_BITS-1:0]   trial;

   bmii_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr = ring_addr(item_ff.slot_cur, item_ff.line_cur);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = ring_addr(item_ff.slot_prev, item_ff.line_cur);
      acc_fin      = acc_ff + ((item_ff.c1_ok && item_ff.l1_ok) ? rd_data : 32'd0);
      mag          = acc_fin[31] ? -acc_fin : acc_fin;
      trial        = {rem_ff[REM_BITS-2:0], quo_ff[QUOT_BITS-1]};

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               item_in  = head;
               state_in = ST_PREV;
            end
         end
         ST_PREV: begin
            state_in = ST_CORNER_A;
         end
         ST_CORNER_A: begin
            s_in     = (item_ff.has_prev ? rd_data : 32'd0) + item_ff.run_sum;
            rd_addr  = ring_addr(item_ff.slot_c1, item_ff.line_cur);
            state_in = ST_CORNER_B;
         end
         ST_CORNER_B: begin
            // store the new table entry; later reads never hit this address
            wr_en    = 1'b1;
            acc_in   = s_ff - (item_ff.c1_ok ? rd_data : 32'd0);
            rd_addr  = ring_addr(item_ff.slot_cur, item_ff.line_l1);
            state_in = ST_CORNER_C;
         end
         ST_CORNER_C: begin
            acc_in   = acc_ff - (item_ff.l1_ok ? rd_data : 32'd0);
            rd_addr  = ring_addr(item_ff.slot_c1, item_ff.line_l1);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            neg_in = acc_fin[31];
            rem_in = REM_BITS'(mag[31:16]);
            quo_in = {mag[15:0], 8'd0};
            cnt_in = '0;
            if (!item_ff.emit) begin
               state_in = ST_IDLE;
            end else if (item_ff.no_data) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle, restoring
            if (trial >= REM_BITS'(item_ff.area)) begin
               rem_in = trial - REM_BITS'(item_ff.area);
               quo_in = {quo_ff[QUOT_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[QUOT_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + QCNT_BITS'(1);
            if (int'(cnt_ff) == QUOT_BITS - 1) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in       = 1'b1;
               out_in.mean_q8     = item_ff.no_data ? 24'd0 : (neg_ff ? -quo_ff : quo_ff);
               out_in.out_sample  = item_ff.out_sample;
               out_in.out_line    = item_ff.out_line;
               out_in.no_data     = item_ff.no_data;
               out_in.last        = item_ff.last;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      s_ff    <= s_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      out_ff  <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

`ifndef SYNTHESIS
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.no_data |-> out_ff.mean_q8 == 24'd0)
      else $error("no_data word carries a nonzero mean");
   a_div_needs_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> item_ff.emit && !item_ff.no_data)
      else $error("divider running for an item without a result");
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result register loaded outside the output step");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_PREV)
      else $error("popped item did not start the ring sequence");
`endif
endmodule
`default_nettype wire

@@ sv/box_mean_integral_image_unit.sv @@
// box_mean_integral_image_unit: top level; register file, front end, item queue and
// back end of the box mean filter. Depends on bmii_pkg, bmii_front, bmii_queue, bmii_back.
//
//  channel | direction | handshake            | payload
//  req     | in        | tvalid/tready        | tdata: pixel
//  rsp     | out       | tvalid/tready        | tdata: mean_q8, out_sample, out_line;
//          |           |                      | tuser: no_data; tlast: last
//  csr     | in        | psel/penable/pready  | 7 registers at 4*i
//
// In the back end an item that gives no result returns to idle after the sum step, a no_data
// result goes straight to the output step, and a mean takes one quotient bit per cycle
// from the shared restoring divider, with four ring reads on the single RAM read port before it.
// The 2-entry queue lets the front accept words while the back end works.
// Reset is synchronous; it clears counters, queue and handshake state; the ring needs no
// clearing. A stalled result holds in the output register while the next item proceeds.
`default_nettype none
module box_mean_integral_image_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] pixel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [23:0] mean_q8, [39:24] out_sample, [49:40] out_line
   output logic             rsp_tuser,   // [0] no_data
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bmii_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;
   logic        csr_write;
   logic        q_full, q_empty, push, pop;
   item_type    push_item, head;
   out_type     out_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = 32'd0;
      unique case (reg_sel)
         REG_IMAGE_SAMPLES: begin
            csr_prdata = 32'(cfg_ff.image_samples);
            if (csr_write) cfg_in.image_samples = csr_pwdata[15:0];
         end
         REG_IMAGE_LINES: begin
            csr_prdata = 32'(cfg_ff.image_lines);
            if (csr_write) cfg_in.image_lines = csr_pwdata[10:0];
         end
         REG_SAMPLE_OFFSET: begin
            csr_prdata = 32'(cfg_ff.sample_offset);
            if (csr_write) cfg_in.sample_offset = csr_pwdata[15:0];
         end
         REG_LINE_OFFSET: begin
            csr_prdata = 32'(cfg_ff.line_offset);
            if (csr_write) cfg_in.line_offset = csr_pwdata[9:0];
         end
         REG_OUT_SAMPLES: begin
            csr_prdata = 32'(cfg_ff.out_samples);
            if (csr_write) cfg_in.out_samples = csr_pwdata[15:0];
         end
         REG_OUT_LINES: begin
            csr_prdata = 32'(cfg_ff.out_lines);
            if (csr_write) cfg_in.out_lines = csr_pwdata[10:0];
         end
         REG_WING_SIZE: begin
            csr_prdata = 32'(cfg_ff.wing_size);
            if (csr_write) cfg_in.wing_size = csr_pwdata[3:0];
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_samples <= 16'd1;
         cfg_ff.image_lines   <= 11'd1;
         cfg_ff.sample_offset <= 16'd0;
         cfg_ff.line_offset   <= 10'd0;
         cfg_ff.out_samples   <= 16'd0;
         cfg_ff.out_lines     <= 11'd0;
         cfg_ff.wing_size     <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmii_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_pixel   (req_tdata),
      .queue_full (q_full),
      .in_ready   (req_tready),
      .push       (push),
      .push_item  (push_item)
   );

   bmii_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   bmii_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .head        (head),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_word    (out_word)
   );

   assign rsp_tdata = {6'd0, out_word.out_line, out_word.out_sample, out_word.mean_q8};
   assign rsp_tuser = out_word.no_data;
   assign rsp_tlast = out_word.last;
endmodule
`default_nettype wire

@@ dv/box_mean_integral_image_unit_test.sv @@
// box_mean_integral_image_unit_test: self-checking bench for the box mean unit; predicts every
// window mean from its own summed-area table and compares all fields. Depends on bmii_pkg.
`default_nettype none
module box_mean_integral_image_unit_test;
   import bmii_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   box_mean_integral_image_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the registers and of the summed-area table
   int unsigned  geom [7];
   logic [31:0]  sat_ring [RING_DEPTH];
   logic [31:0]  column_total;
   int unsigned  at_column, at_line;

   logic [15:0]  pixel_queue [$];
   out_type      mean_fifo [$];
   int           failures = 0;
   int           random_pixels = 0;
   bit           sender_steady = 1'b0;
   bit           receiver_steady = 1'b0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           quiet_cycles = 0;

   function automatic int unsigned slot_of(longint col, longint line);
      return int'((col % RING_SLOTS) * MAX_LINES + (line % MAX_LINES));
   endfunction

   function automatic logic [31:0] corner(longint col, longint line);
      if (col < 0 || line < 0) return 32'd0;
      return sat_ring[slot_of(col, line)];
   endfunction

   function automatic void predict_mean(logic [15:0] pix);
      int unsigned samples, lines, w, cc, ll;
      logic [31:0] prev, s, sum;
      longint c, l, c1, l1, c2, l2, mean, n;
      out_type e;
      samples = (geom[REG_IMAGE_SAMPLES] == 0) ? 1 : geom[REG_IMAGE_SAMPLES];
      lines = (geom[REG_IMAGE_LINES] == 0) ? 1 : geom[REG_IMAGE_LINES];
      if (lines > MAX_LINES) lines = MAX_LINES;
      w = (geom[REG_WING_SIZE] > MAX_WING) ? MAX_WING : geom[REG_WING_SIZE];
      if (at_line >= lines) begin
         at_line = 0;
         column_total = 0;
         at_column++;
      end
      if (at_column >= samples) at_column = 0;
      cc = at_column;
      ll = at_line;
      column_total = column_total + {{16{pix[15]}}, pix};
      prev = (cc > 0) ? sat_ring[slot_of(cc - 1, ll)] : 32'd0;
      s = prev + column_total;
      sat_ring[slot_of(cc, ll)] = s;
      // advance to next line, column or frame
      if (ll + 1 >= lines) begin
         at_line = 0;
         column_total = 0;
         at_column = (cc + 1 >= samples) ? 0 : cc + 1;
      end else begin
         at_line = ll + 1;
      end
      c2 = cc;
      l2 = ll;
      c = c2 - w - longint'(geom[REG_SAMPLE_OFFSET]);
      l = l2 - w - longint'(geom[REG_LINE_OFFSET]);
      if (c < 0 || c >= longint'(geom[REG_OUT_SAMPLES]) || l < 0 ||
          l >= longint'(geom[REG_OUT_LINES])) return;
      c1 = c2 - 2 * w - 1;
      l1 = l2 - 2 * w - 1;
      mean = 0;
      e.no_data = (c1 < -1) || (l1 < -1);
      if (!e.no_data) begin
         sum = s - corner(c1, l2) - corner(c2, l1) + corner(c1, l1);
         n = (2 * w + 1) * (2 * w + 1);
         mean = (longint'($signed(sum)) * 256) / n;
      end
      e.mean_q8 = mean[23:0];
      e.out_sample = c[15:0];
      e.out_line = l[9:0];
      e.last = (c == longint'(geom[REG_OUT_SAMPLES]) - 1) &&
               (l == longint'(geom[REG_OUT_LINES]) - 1);
      mean_fifo.push_back(e);
   endfunction

   // mostly back to back, sometimes short gaps, rarely long ones
   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 19);
      if (steady || r < 13) return 0;
      if (r < 19) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic [15:0] random_pixel();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      logic        nv;
      logic [15:0] nd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         nv = req_tvalid;
         nd = req_tdata;
         if (req_tvalid && req_tready) begin
            predict_mean(req_tdata);
            nv = 1'b0;
            send_gap = pick_gap(sender_steady);
         end
         if (!nv) begin
            if (send_gap > 0) send_gap--;
            else if (pixel_queue.size() > 0) begin
               nv = 1'b1;
               nd = pixel_queue.pop_front();
            end
         end
         req_tvalid <= nv;
         req_tdata <= nd;
      end
   end

   // receiver, checker and watchdog
   always @(posedge clock) begin
      out_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (mean_fifo.size() == 0) begin
               $error("unexpected result word: %h", rsp_tdata);
               failures++;
            end else begin
               e = mean_fifo.pop_front();
               if (rsp_tdata[23:0] !== e.mean_q8) begin
                  $error("mean_q8: expected %h, got %h", e.mean_q8, rsp_tdata[23:0]);
                  failures++;
               end
               if (rsp_tdata[39:24] !== e.out_sample) begin
                  $error("out_sample: expected %0d, got %0d", e.out_sample, rsp_tdata[39:24]);
                  failures++;
               end
               if (rsp_tdata[49:40] !== e.out_line) begin
                  $error("out_line: expected %0d, got %0d", e.out_line, rsp_tdata[49:40]);
                  failures++;
               end
               if (rsp_tuser !== e.no_data) begin
                  $error("no_data: expected %b, got %b", e.no_data, rsp_tuser);
                  failures++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last: expected %b, got %b", e.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap(receiver_steady);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
         else if (req_tvalid || pixel_queue.size() > 0 || mean_fifo.size() > 0) quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic csr_write(csr_reg_type r, int unsigned v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r[2:0], 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (r)
         REG_IMAGE_LINES, REG_OUT_LINES: geom[r] = v & 32'h7FF;
         REG_LINE_OFFSET:                geom[r] = v & 32'h3FF;
         REG_WING_SIZE:                  geom[r] = v & 32'hF;
         default:                        geom[r] = v & 32'hFFFF;
      endcase
   endtask

   // hold until the block has drained, then let any result-free items finish
   task automatic drain();
      wait (pixel_queue.size() == 0 && !req_tvalid && mean_fifo.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned samples, int unsigned lines, int unsigned soff,
                               int unsigned loff, int unsigned os, int unsigned ol,
                               int unsigned w);
      drain();
      csr_write(REG_IMAGE_SAMPLES, samples);
      csr_write(REG_IMAGE_LINES, lines);
      csr_write(REG_SAMPLE_OFFSET, soff);
      csr_write(REG_LINE_OFFSET, loff);
      csr_write(REG_OUT_SAMPLES, os);
      csr_write(REG_OUT_LINES, ol);
      csr_write(REG_WING_SIZE, w);
   endtask

   task automatic push_frames(int unsigned pixels);
      for (int unsigned i = 0; i < pixels; i++) pixel_queue.push_back(random_pixel());
   endtask

   initial begin
      int unsigned samples, lines, frames, eff_lines;
      geom[REG_IMAGE_SAMPLES] = 1;
      geom[REG_IMAGE_LINES] = 1;
      for (int i = 2; i < 7; i++) geom[i] = 0;
      column_total = 0;
      at_column = 0;
      at_line = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: no output grid, so nothing comes out
      pixel_queue.push_back(16'h1234);
      pixel_queue.push_back(16'hFFFF);

      // zero sizes count as one: every pixel is its own frame and its own mean
      set_geometry(0, 0, 0, 0, 1, 1, 0);
      pixel_queue.push_back(16'h7FFF);
      pixel_queue.push_back(16'h8000);
      pixel_queue.push_back(16'h0000);
      pixel_queue.push_back(16'hFFFF);
      pixel_queue.push_back(16'h0001);
      pixel_queue.push_back(16'h5555);
      pixel_queue.push_back(16'hAAAA);

      // grid far outside the image: no result ever completes
      set_geometry(3, 3, 65535, 1023, 65535, 1024, 1);
      push_frames(9);

      // small window with corners at minus one and windows reaching before the start
      set_geometry(4, 4, 0, 0, 4, 4, 1);
      push_frames(16);

      // widest wing, window reaches before start
      set_geometry(16, 16, 0, 0, 1, 1, 15);
      push_frames(256);

      // line count saturates to the maximum; single column of means
      set_geometry(1, 2047, 0, 0, 1, 1024, 0);
      push_frames(MAX_LINES);

      while (random_pixels < 136) begin
         samples = $urandom_range(1, 10);
         lines = $urandom_range(1, 12);
         frames = $urandom_range(1, 3);
         set_geometry(samples, lines, $urandom_range(0, 2), $urandom_range(0, 2),
                      $urandom_range(0, samples + 1), $urandom_range(0, lines + 1),
                      $urandom_range(0, 4));
         sender_steady = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         eff_lines = lines;
         push_frames(frames * samples * eff_lines);
         random_pixels += frames * samples * eff_lines;
      end

      drain();
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire
